>>> sv/limit_order_book_matcher_macros.svh
// Assertion macros used by the order book datapath RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LOBM_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("order book check failed");

// Next-cycle implication, checked outside reset.
`define LOBM_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("order book check failed");

`endif

>>> sv/lobm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the order book.
// No dependencies.
package lobm_pkg;

    localparam int MAX_ORDERS = 32;
    localparam int ID_BITS    = 16;
    localparam int PRICE_BITS = 32;
    localparam int QTY_BITS   = 32;
    localparam int IDX_W      = $clog2(MAX_ORDERS);
    localparam int CNT_W      = $clog2(MAX_ORDERS + 1);
    localparam int SEEN_W     = 32;
    localparam int SEEN_SEL   = $clog2(SEEN_W);
    localparam int SEEN_ROWS  = (1 << ID_BITS) / SEEN_W;
    localparam int SEEN_AW    = ID_BITS - SEEN_SEL;

    typedef enum logic [1:0] {
        MODE_LIMIT  = 2'd0,
        MODE_MARKET = 2'd1,
        MODE_CANCEL = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_CANCELLED = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_QUERY     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR_STEP,
        OP_LOAD,
        OP_REJECT,
        OP_SEEN_WR,
        OP_SCAN_START,
        OP_SCAN_MATCH,
        OP_SCAN_CANCEL,
        OP_SCAN_BOOK,
        OP_FILL,
        OP_DROP,
        OP_REST,
        OP_SUMMARY
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic  clr_done;
        logic  reject;
        logic  scan_last;
        logic  found;
        logic  limit_stop;
        logic  rem_zero;
        logic  rows_full;
        logic  best_empty;
        logic  out_free;
        t_mode mode;
    } t_stat;

endpackage

>>> sv/lobm_ctrl.sv
// Sequencing state machine of the order book: issues datapath commands.
// Depends on lobm_pkg.
module lobm_ctrl
    import lobm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  [1:0] i_mode,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_MSTART, S_MSCAN, S_MDEC, S_MDROP, S_REST,
        S_CSTART, S_CSCAN, S_CDROP, S_BSTART, S_BSCAN, S_SUM
    } t_state;

    t_state r_state, n_state;
    t_state post_match;

    assign post_match = (i_stat.mode == MODE_LIMIT && !i_stat.rem_zero) ? S_REST : S_BSTART;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLR_STEP;
                if (i_stat.clr_done) begin
                    o_cmd.op = OP_NONE;
                    n_state  = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    case (t_mode'(i_mode))
                        MODE_LIMIT, MODE_MARKET: n_state = S_CHECK;
                        MODE_CANCEL:             n_state = S_CSTART;
                        default:                 n_state = S_BSTART;
                    endcase
                end
            end
            S_CHECK: begin
                if (i_stat.reject) begin
                    o_cmd.op = OP_REJECT;
                    n_state  = S_BSTART;
                end else begin
                    o_cmd.op = OP_SEEN_WR;
                    n_state  = S_MSTART;
                end
            end
            S_MSTART: begin
                o_cmd.op = OP_SCAN_START;
                n_state  = S_MSCAN;
            end
            S_MSCAN: begin
                o_cmd.op = OP_SCAN_MATCH;
                if (i_stat.scan_last) n_state = S_MDEC;
            end
            S_MDEC: begin
                if (!i_stat.found || i_stat.limit_stop) begin
                    n_state = post_match;
                end else if (i_stat.out_free) begin
                    o_cmd.op = OP_FILL;
                    n_state  = S_MDROP;
                end
            end
            S_MDROP: begin
                if (i_stat.best_empty) o_cmd.op = OP_DROP;
                if (!i_stat.rem_zero && !i_stat.rows_full) n_state = S_MSTART;
                else n_state = post_match;
            end
            S_REST: begin
                o_cmd.op = OP_REST;
                n_state  = S_BSTART;
            end
            S_CSTART: begin
                o_cmd.op = OP_SCAN_START;
                n_state  = S_CSCAN;
            end
            S_CSCAN: begin
                o_cmd.op = OP_SCAN_CANCEL;
                if (i_stat.scan_last) n_state = S_CDROP;
            end
            S_CDROP: begin
                if (i_stat.found) o_cmd.op = OP_DROP;
                n_state = S_BSTART;
            end
            S_BSTART: begin
                o_cmd.op = OP_SCAN_START;
                n_state  = S_BSCAN;
            end
            S_BSCAN: begin
                o_cmd.op = OP_SCAN_BOOK;
                if (i_stat.scan_last) n_state = S_SUM;
            end
            S_SUM: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_SUMMARY;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/lobm_dp.sv
// Datapath of the order book: seen-id memory, entry store, scan unit and output row register.
// Depends on lobm_pkg and the assertion macro header.
`include "limit_order_book_matcher_macros.svh"
module lobm_dp
    import lobm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    input  logic  [1:0]  i_mode,
    input  logic  [15:0] i_order_id,
    input  logic         i_buy_side,
    input  logic  [31:0] i_limit_price,
    input  logic  [31:0] i_order_quantity,
    input  logic         i_out_stall,
    output logic         o_out_valid,
    output logic         o_last_of_run,
    output logic  [15:0] o_buyer_id,
    output logic  [15:0] o_seller_id,
    output logic  [31:0] o_trade_price,
    output logic  [31:0] o_fill_quantity,
    output logic  [31:0] o_trade_sequence,
    output logic  [2:0]  o_status,
    output logic  [31:0] o_leaves_qty,
    output logic         o_best_bid_valid,
    output logic  [31:0] o_best_bid,
    output logic         o_best_ask_valid,
    output logic  [31:0] o_best_ask
);

    // seen-id bitmap, one row of SEEN_W ids per address
    logic [SEEN_W-1:0] seen_mem [SEEN_ROWS];
    logic [SEEN_W-1:0] r_seen_rd;
    logic [SEEN_AW-1:0] r_clr_addr;
    logic r_clr_done;

    // item
    t_mode               r_mode;
    logic [ID_BITS-1:0]  r_id;
    logic                r_buy;
    logic [PRICE_BITS-1:0] r_limit;
    logic [QTY_BITS-1:0] r_qty, r_rem;
    t_status             r_status;
    logic [CNT_W-1:0]    r_rows;

    // entry store
    logic [MAX_ORDERS-1:0] r_valid;
    logic                  r_side  [MAX_ORDERS];
    logic [ID_BITS-1:0]    r_eid   [MAX_ORDERS];
    logic [PRICE_BITS-1:0] r_price [MAX_ORDERS];
    logic [QTY_BITS-1:0]   r_erem  [MAX_ORDERS];
    logic [IDX_W-1:0]      r_rank  [MAX_ORDERS];
    logic [CNT_W-1:0]      r_count;
    logic [31:0]           r_trade_cnt;

    // scan unit
    logic [IDX_W-1:0]      r_scan_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx, r_best_rank;
    logic [PRICE_BITS-1:0] r_best_price;
    logic [ID_BITS-1:0]    r_best_id;
    logic [QTY_BITS-1:0]   r_best_rem;
    logic                  r_bid_v, r_ask_v;
    logic [PRICE_BITS-1:0] r_bid, r_ask;

    logic                  s_side;
    logic [ID_BITS-1:0]    s_id;
    logic [PRICE_BITS-1:0] s_price;
    logic [QTY_BITS-1:0]   s_rem;
    logic [IDX_W-1:0]      s_rank;
    logic                  s_valid, opp_side, better;
    logic [IDX_W-1:0]      free_idx;
    logic                  free_any;
    logic [QTY_BITS-1:0]   ex;
    logic                  out_free;

    assign s_valid  = r_valid[r_scan_idx];
    assign s_side   = r_side[r_scan_idx];
    assign s_id     = r_eid[r_scan_idx];
    assign s_price  = r_price[r_scan_idx];
    assign s_rem    = r_erem[r_scan_idx];
    assign s_rank   = r_rank[r_scan_idx];
    assign opp_side = ~r_buy;

    // bids prefer higher, asks lower; equal price goes to the older rank
    always_comb begin
        if (!r_found) better = 1'b1;
        else if (s_price != r_best_price)
            better = opp_side ? (s_price > r_best_price) : (s_price < r_best_price);
        else better = (s_rank < r_best_rank);
    end

    always_comb begin
        free_idx = '0;
        for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_idx = IDX_W'(i);
        end
    end
    assign free_any = ~&r_valid;
    assign ex       = (r_rem < r_best_rem) ? r_rem : r_best_rem;
    assign out_free = !o_out_valid || !i_out_stall;

    assign o_stat.clr_done   = r_clr_done;
    assign o_stat.reject     = (r_qty == '0) || r_seen_rd[r_id[SEEN_SEL-1:0]];
    assign o_stat.scan_last  = (r_scan_idx == IDX_W'(MAX_ORDERS - 1));
    assign o_stat.found      = r_found;
    assign o_stat.limit_stop = (r_mode == MODE_LIMIT) &&
                               (r_buy ? (r_best_price > r_limit) : (r_best_price < r_limit));
    assign o_stat.rem_zero   = (r_rem == '0);
    assign o_stat.rows_full  = (r_rows == CNT_W'(MAX_ORDERS));
    assign o_stat.best_empty = (r_best_rem == '0);
    assign o_stat.out_free   = out_free;
    assign o_stat.mode       = r_mode;

    // seen memory: clearing pass, read on load, set on acceptance
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLR_STEP) begin
            seen_mem[r_clr_addr] <= '0;
        end else if (i_cmd.op == OP_SEEN_WR) begin
            seen_mem[r_id[ID_BITS-1:SEEN_SEL]] <= r_seen_rd | (SEEN_W'(1) << r_id[SEEN_SEL-1:0]);
        end
        if (i_cmd.op == OP_LOAD) begin
            r_seen_rd <= seen_mem[i_order_id[ID_BITS-1:SEEN_SEL]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.op == OP_CLR_STEP) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == SEEN_AW'(SEEN_ROWS - 1)) r_clr_done <= 1'b1;
        end
    end

    // item registers and scan unit
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode  <= t_mode'(i_mode);
                r_id    <= i_order_id[ID_BITS-1:0];
                r_buy   <= i_buy_side;
                r_limit <= i_limit_price[PRICE_BITS-1:0];
                r_qty   <= i_order_quantity[QTY_BITS-1:0];
                r_rem   <= (t_mode'(i_mode) == MODE_LIMIT || t_mode'(i_mode) == MODE_MARKET)
                           ? i_order_quantity[QTY_BITS-1:0] : '0;
                r_rows  <= '0;
                case (t_mode'(i_mode))
                    MODE_CANCEL: r_status <= ST_NOT_FOUND;
                    MODE_QUERY:  r_status <= ST_QUERY;
                    default:     r_status <= ST_ACCEPTED;
                endcase
            end
            OP_REJECT: r_status <= ST_REJECTED;
            OP_SCAN_START: begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
                r_bid_v    <= 1'b0;
                r_ask_v    <= 1'b0;
            end
            OP_SCAN_MATCH: begin
                r_scan_idx <= r_scan_idx + 1'b1;
                if (s_valid && s_side == opp_side && better) begin
                    r_found      <= 1'b1;
                    r_best_idx   <= r_scan_idx;
                    r_best_rank  <= s_rank;
                    r_best_price <= s_price;
                    r_best_id    <= s_id;
                    r_best_rem   <= s_rem;
                end
            end
            OP_SCAN_CANCEL: begin
                r_scan_idx <= r_scan_idx + 1'b1;
                if (!r_found && s_valid && s_id == r_id) begin
                    r_found     <= 1'b1;
                    r_best_idx  <= r_scan_idx;
                    r_best_rank <= s_rank;
                end
            end
            OP_SCAN_BOOK: begin
                r_scan_idx <= r_scan_idx + 1'b1;
                if (s_valid && s_side && (!r_bid_v || s_price > r_bid)) begin
                    r_bid_v <= 1'b1;
                    r_bid   <= s_price;
                end
                if (s_valid && !s_side && (!r_ask_v || s_price < r_ask)) begin
                    r_ask_v <= 1'b1;
                    r_ask   <= s_price;
                end
            end
            OP_FILL: begin
                r_rem      <= r_rem - ex;
                r_best_rem <= r_best_rem - ex;
                r_rows     <= r_rows + 1'b1;
            end
            OP_DROP: begin
                if (r_mode == MODE_CANCEL) r_status <= ST_CANCELLED;
            end
            OP_REST: begin
                if (r_count >= CNT_W'(MAX_ORDERS) || !free_any) r_status <= ST_DROPPED;
            end
            default: ;
        endcase
    end

    // entry store payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FILL) begin
            r_erem[r_best_idx] <= r_best_rem - ex;
        end else if (i_cmd.op == OP_REST && r_count < CNT_W'(MAX_ORDERS) && free_any) begin
            r_side[free_idx]  <= r_buy;
            r_eid[free_idx]   <= r_id;
            r_price[free_idx] <= r_limit;
            r_erem[free_idx]  <= r_rem;
            r_rank[free_idx]  <= r_count[IDX_W-1:0];
        end else if (i_cmd.op == OP_DROP) begin
            for (int i = 0; i < MAX_ORDERS; i++) begin
                if (r_valid[i] && r_rank[i] > r_best_rank) r_rank[i] <= r_rank[i] - 1'b1;
            end
        end
    end

    // entry store control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_trade_cnt <= '0;
        end else begin
            case (i_cmd.op)
                OP_FILL: r_trade_cnt <= r_trade_cnt + 1'b1;
                OP_DROP: begin
                    r_valid[r_best_idx] <= 1'b0;
                    r_count             <= r_count - 1'b1;
                end
                OP_REST: begin
                    if (r_count < CNT_W'(MAX_ORDERS) && free_any) begin
                        r_valid[free_idx] <= 1'b1;
                        r_count           <= r_count + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // output row register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_FILL || i_cmd.op == OP_SUMMARY) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FILL) begin
            o_last_of_run    <= 1'b0;
            o_buyer_id       <= r_buy ? 16'(r_id) : 16'(r_best_id);
            o_seller_id      <= r_buy ? 16'(r_best_id) : 16'(r_id);
            o_trade_price    <= 32'(r_best_price);
            o_fill_quantity  <= 32'(ex);
            o_trade_sequence <= r_trade_cnt;
            o_status         <= 3'(ST_ACCEPTED);
            o_leaves_qty     <= '0;
            o_best_bid_valid <= 1'b0;
            o_best_bid       <= '0;
            o_best_ask_valid <= 1'b0;
            o_best_ask       <= '0;
        end else if (i_cmd.op == OP_SUMMARY) begin
            o_last_of_run    <= 1'b1;
            o_buyer_id       <= '0;
            o_seller_id      <= '0;
            o_trade_price    <= '0;
            o_fill_quantity  <= (r_status == ST_ACCEPTED || r_status == ST_DROPPED)
                                ? 32'(r_qty - r_rem) : '0;
            o_trade_sequence <= '0;
            o_status         <= 3'(r_status);
            o_leaves_qty     <= 32'(r_rem);
            o_best_bid_valid <= r_bid_v;
            o_best_bid       <= r_bid_v ? 32'(r_bid) : '0;
            o_best_ask_valid <= r_ask_v;
            o_best_ask       <= r_ask_v ? 32'(r_ask) : '0;
        end
    end

    `LOBM_AST_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_ORDERS))
    `LOBM_AST_IMP(a_count_valid, 1'b1, $countones(r_valid) == 32'(r_count))
    `LOBM_AST_NXT(a_fill_row, i_cmd.op == OP_FILL, o_out_valid && !o_last_of_run)
    `LOBM_AST_NXT(a_trade_seq, i_cmd.op == OP_FILL, r_trade_cnt == $past(r_trade_cnt) + 32'd1)

endmodule

>>> sv/limit_order_book_matcher.sv
// Top level of the price-time priority limit order book.
// Depends on lobm_pkg, lobm_ctrl and lobm_dp.
//
// Input channel: i_in_valid / o_in_stall with fields i_mode, i_order_id, i_buy_side,
// i_limit_price, i_order_quantity; one transfer carries one order, cancel or query.
// Output channel: o_out_valid / i_out_stall; each transfer is one row. A submitted
// order gives one trade row per fill, then every item ends with a summary row
// (o_last_of_run high) holding status, totals and the best bid and ask.
// One item is in work at a time. Each best-price search sweeps the 32-entry store
// one entry a cycle. Every item ends with a book sweep for the best bid and ask. A
// query makes only that sweep, as does a rejected submit; a cancel first sweeps for
// its id. A submit searches again after each fill until a search comes up empty or
// beyond the limit, or quantity or rows run out, with at most 32 fills; a limit
// remainder then rests if the store has room.
// After reset the seen-id memory is cleared one 32-bit row a cycle: o_in_stall
// stays high until the clearing is done, before the first item is taken.
// A stalled receiver holds the current row; the book waits before each new row
// until the output register is free, and nothing is lost.
module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_order_id,
    input  logic        i_buy_side,
    input  logic [31:0] i_limit_price,
    input  logic [31:0] i_order_quantity,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_last_of_run,
    output logic [15:0] o_buyer_id,
    output logic [15:0] o_seller_id,
    output logic [31:0] o_trade_price,
    output logic [31:0] o_fill_quantity,
    output logic [31:0] o_trade_sequence,
    output logic [2:0]  o_status,
    output logic [31:0] o_leaves_qty,
    output logic        o_best_bid_valid,
    output logic [31:0] o_best_bid,
    output logic        o_best_ask_valid,
    output logic [31:0] o_best_ask
);

    t_cmd  cmd;
    t_stat stat;

    // controller: sequences load, id check, match and cancel sweeps, fills, drops, rest, book sweep and summary
    lobm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath: seen-id memory, entry store, sweep unit, output row register
    lobm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_mode           (i_mode),
        .i_order_id       (i_order_id),
        .i_buy_side       (i_buy_side),
        .i_limit_price    (i_limit_price),
        .i_order_quantity (i_order_quantity),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_last_of_run    (o_last_of_run),
        .o_buyer_id       (o_buyer_id),
        .o_seller_id      (o_seller_id),
        .o_trade_price    (o_trade_price),
        .o_fill_quantity  (o_fill_quantity),
        .o_trade_sequence (o_trade_sequence),
        .o_status         (o_status),
        .o_leaves_qty     (o_leaves_qty),
        .o_best_bid_valid (o_best_bid_valid),
        .o_best_bid       (o_best_bid),
        .o_best_ask_valid (o_best_ask_valid),
        .o_best_ask       (o_best_ask)
    );

endmodule

>>> tb/limit_order_book_matcher_test.sv
// Self-checking testbench for the price-time priority order book matcher.
// Depends on lobm_pkg and limit_order_book_matcher; a built-in book model predicts every row.
module limit_order_book_matcher_test;
    import lobm_pkg::*;

    // one output row, as the block presents it
    typedef struct packed {
        logic        last;
        logic [15:0] buy_id;
        logic [15:0] sell_id;
        logic [31:0] price;
        logic [31:0] fill;
        logic [31:0] seq;
        logic [2:0]  status;
        logic [31:0] unfilled;
        logic        bid_ok;
        logic [31:0] bid;
        logic        ask_ok;
        logic [31:0] ask;
    } t_row;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] id;
        logic        buy;
        logic [31:0] px;
        logic [31:0] qty;
    } t_order;

    // directed row: order plus an optional hand-typed summary
    typedef struct packed {
        t_order      ord;
        logic        has_sum;
        t_status     status;
        logic [31:0] unfilled;
    } t_dir;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_mode = '0;
    logic [15:0] i_order_id = '0;
    logic        i_buy_side = 1'b0;
    logic [31:0] i_limit_price = '0;
    logic [31:0] i_order_quantity = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_last_of_run;
    logic [15:0] o_buyer_id, o_seller_id;
    logic [31:0] o_trade_price, o_fill_quantity, o_trade_sequence;
    logic [2:0]  o_status;
    logic [31:0] o_leaves_qty, o_best_bid, o_best_ask;
    logic        o_best_bid_valid, o_best_ask_valid;

    limit_order_book_matcher dut (.*);

    always #1 i_clk = ~i_clk;

    // book shadow
    bit          seen_id [bit [15:0]];
    bit          bk_valid [MAX_ORDERS];
    bit          bk_side [MAX_ORDERS];
    bit [15:0]   bk_id [MAX_ORDERS];
    bit [31:0]   bk_px [MAX_ORDERS];
    bit [31:0]   bk_rem [MAX_ORDERS];
    int          bk_rank [MAX_ORDERS];
    int          resting;
    bit [31:0]   trade_seq;

    t_row        rows_due [$];
    t_dir        dir_rows [$];
    int          failures = 0;
    bit          quiet = 1'b0;   // no idling near the end
    int          id_pool = 0;    // ids handed out for well-formed orders

    function automatic int best_of(bit side);
        int b = -1;
        for (int i = 0; i < MAX_ORDERS; i++) begin
            if (!bk_valid[i] || bk_side[i] != side) continue;
            if (b < 0) b = i;
            else if (bk_px[i] != bk_px[b]) begin
                if (side ? bk_px[i] > bk_px[b] : bk_px[i] < bk_px[b]) b = i;
            end else if (bk_rank[i] < bk_rank[b]) b = i;
        end
        return b;
    endfunction

    function automatic void remove_entry(int k);
        bk_valid[k] = 0;
        for (int i = 0; i < MAX_ORDERS; i++)
            if (bk_valid[i] && bk_rank[i] > bk_rank[k]) bk_rank[i]--;
        if (resting > 0) resting--;
    endfunction

    // work out the rows one order gives and queue them
    function automatic void match_order(t_order o);
        t_row   r;
        t_status st = ST_QUERY;
        bit [31:0] rem, filled = 0, unf = 0, ex;
        int     k, n = 0, slot;
        if (o.mode == MODE_LIMIT || o.mode == MODE_MARKET) begin
            if (o.qty == 0 || seen_id.exists(o.id)) begin
                st = ST_REJECTED;
                unf = o.qty;
            end else begin
                seen_id[o.id] = 1;
                st = ST_ACCEPTED;
                rem = o.qty;
                while (rem > 0 && n < MAX_ORDERS) begin
                    k = best_of(!o.buy);
                    if (k < 0) break;
                    if (o.mode == MODE_LIMIT &&
                        (o.buy ? bk_px[k] > o.px : bk_px[k] < o.px)) break;
                    ex = rem < bk_rem[k] ? rem : bk_rem[k];
                    rem -= ex;
                    bk_rem[k] -= ex;
                    r = '0;
                    r.buy_id = o.buy ? o.id : bk_id[k];
                    r.sell_id = o.buy ? bk_id[k] : o.id;
                    r.price = bk_px[k];
                    r.fill = ex;
                    r.seq = trade_seq;
                    rows_due = {rows_due, r};
                    trade_seq++;
                    n++;
                    if (bk_rem[k] == 0) remove_entry(k);
                end
                filled = o.qty - rem;
                unf = rem;
                if (o.mode == MODE_LIMIT && rem > 0) begin
                    slot = -1;
                    for (int i = 0; i < MAX_ORDERS; i++)
                        if (!bk_valid[i] && slot < 0) slot = i;
                    if (resting >= MAX_ORDERS || slot < 0) st = ST_DROPPED;
                    else begin
                        bk_valid[slot] = 1;
                        bk_side[slot] = o.buy;
                        bk_id[slot] = o.id;
                        bk_px[slot] = o.px;
                        bk_rem[slot] = rem;
                        bk_rank[slot] = resting;
                        resting++;
                    end
                end
            end
        end else if (o.mode == MODE_CANCEL) begin
            st = ST_NOT_FOUND;
            for (int i = 0; i < MAX_ORDERS; i++)
                if (st == ST_NOT_FOUND && bk_valid[i] && bk_id[i] == o.id) begin
                    remove_entry(i);
                    st = ST_CANCELLED;
                end
        end
        r = '0;
        r.last = 1'b1;
        r.fill = filled;
        r.status = st;
        r.unfilled = unf;
        k = best_of(1'b1);
        if (k >= 0) begin r.bid_ok = 1; r.bid = bk_px[k]; end
        k = best_of(1'b0);
        if (k >= 0) begin r.ask_ok = 1; r.ask = bk_px[k]; end
        rows_due = {rows_due, r};
    endfunction

    // send one order: an optional random idle burst first, then hold until taken
    task automatic send_order(t_order o);
        if (!quiet && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= o.mode;
        i_order_id <= o.id;
        i_buy_side <= o.buy;
        i_limit_price <= o.px;
        i_order_quantity <= o.qty;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        match_order(o);
    endtask

    // receiver stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(0, 12)) @(posedge i_clk);
        end
    end

    // checker: every transfer against the oldest expected row
    always @(posedge i_clk) begin
        t_row got, exp_row;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_last_of_run, o_buyer_id, o_seller_id, o_trade_price,
                   o_fill_quantity, o_trade_sequence, o_status, o_leaves_qty,
                   o_best_bid_valid, o_best_bid, o_best_ask_valid, o_best_ask};
            if (rows_due.size() == 0) begin
                $display("%0t unexpected row expected none actual %h", $time, got);
                failures++;
            end else begin
                exp_row = rows_due.pop_front();
                if (got.last !== exp_row.last) begin
                    $display("%0t last_of_run expected %0d actual %0d", $time,
                             exp_row.last, got.last);
                    failures++;
                end
                if (got.buy_id !== exp_row.buy_id) begin
                    $display("%0t buyer id expected %0d actual %0d", $time,
                             exp_row.buy_id, got.buy_id);
                    failures++;
                end
                if (got.sell_id !== exp_row.sell_id) begin
                    $display("%0t seller id expected %0d actual %0d", $time,
                             exp_row.sell_id, got.sell_id);
                    failures++;
                end
                if (got.price !== exp_row.price) begin
                    $display("%0t trade_price expected %0d actual %0d", $time,
                             exp_row.price, got.price);
                    failures++;
                end
                if (got.fill !== exp_row.fill) begin
                    $display("%0t fill_quantity expected %0d actual %0d", $time,
                             exp_row.fill, got.fill);
                    failures++;
                end
                if (got.seq !== exp_row.seq) begin
                    $display("%0t trade_sequence expected %0d actual %0d", $time,
                             exp_row.seq, got.seq);
                    failures++;
                end
                if (got.status !== exp_row.status) begin
                    $display("%0t status expected %0d actual %0d", $time,
                             exp_row.status, got.status);
                    failures++;
                end
                if (got.unfilled !== exp_row.unfilled) begin
                    $display("%0t leaves qty expected %0d actual %0d", $time,
                             exp_row.unfilled, got.unfilled);
                    failures++;
                end
                if (got.bid_ok !== exp_row.bid_ok || got.bid !== exp_row.bid) begin
                    $display("%0t best bid expected %0d/%0d actual %0d/%0d", $time,
                             exp_row.bid_ok, exp_row.bid, got.bid_ok, got.bid);
                    failures++;
                end
                if (got.ask_ok !== exp_row.ask_ok || got.ask !== exp_row.ask) begin
                    $display("%0t best ask expected %0d/%0d actual %0d/%0d", $time,
                             exp_row.ask_ok, exp_row.ask, got.ask_ok, got.ask);
                    failures++;
                end
            end
        end
    end

    function automatic t_order mk(t_mode m, bit [15:0] id, bit buy, bit [31:0] px, bit [31:0] q);
        t_order o;
        o.mode = m; o.id = id; o.buy = buy; o.px = px; o.qty = q;
        return o;
    endfunction

    function automatic void add_dir(t_order o, bit has_sum, t_status st, bit [31:0] unf);
        t_dir d;
        d.ord = o; d.has_sum = has_sum; d.status = st; d.unfilled = unf;
        dir_rows = {dir_rows, d};
    endfunction

    // random order: mostly well-formed in a narrow price band so books cross often
    function automatic t_order rand_order();
        t_order o;
        int pick = $urandom_range(99);
        o = mk(MODE_LIMIT, 16'($urandom), $urandom_range(1), 32'($urandom), 32'($urandom));
        if (pick < 80) begin
            o.mode = t_mode'(pick < 60 ? MODE_LIMIT : pick < 70 ? MODE_MARKET :
                             pick < 77 ? MODE_CANCEL : MODE_QUERY);
            if (o.mode == MODE_CANCEL) o.id = 16'(1000 + $urandom_range(id_pool));
            else begin
                id_pool++;
                o.id = 16'(1000 + id_pool);
            end
            o.px = 32'(1000 + $urandom_range(20));
            o.qty = $urandom_range(9) == 0 ? 32'($urandom) : 32'($urandom_range(1, 50));
        end else if (pick < 85) o.qty = 0;
        else if (pick < 90) o.id = 16'(1000 + $urandom_range(id_pool));
        return o;
    endfunction

    initial begin
        t_row  last_sum;
        int    wait_cycles;
        // directed table: extremes, every mode, rejects, cancels, full book
        add_dir(mk(MODE_QUERY, 16'hFFFF, 1, '1, '1), 1, ST_QUERY, 0);
        add_dir(mk(MODE_LIMIT, 16'h0000, 1, 32'd0, 32'd0), 1, ST_REJECTED, 0);
        add_dir(mk(MODE_MARKET, 16'h0001, 0, 32'd0, 32'hFFFF_FFFF), 1, ST_ACCEPTED,
                32'hFFFF_FFFF);
        add_dir(mk(MODE_MARKET, 16'h0001, 1, 32'd5, 32'd3), 1, ST_REJECTED, 32'd3);
        add_dir(mk(MODE_CANCEL, 16'h0001, 0, 32'd0, 32'd0), 1, ST_NOT_FOUND, 0);
        add_dir(mk(MODE_LIMIT, 16'hFFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, ST_ACCEPTED, 0);
        add_dir(mk(MODE_LIMIT, 16'h0002, 0, 32'd0, 32'd10), 0, ST_ACCEPTED, 0);
        add_dir(mk(MODE_LIMIT, 16'h0003, 1, 32'd100, 32'd7), 0, ST_ACCEPTED, 0);
        add_dir(mk(MODE_LIMIT, 16'h0004, 1, 32'd100, 32'd7), 0, ST_ACCEPTED, 0);
        add_dir(mk(MODE_MARKET, 16'h0005, 0, 32'd0, 32'd20), 0, ST_ACCEPTED, 0);
        add_dir(mk(MODE_CANCEL, 16'h0004, 1, '1, '1), 0, ST_ACCEPTED, 0);
        add_dir(mk(MODE_CANCEL, 16'h0004, 0, 0, 0), 1, ST_NOT_FOUND, 0);
        add_dir(mk(MODE_LIMIT, 16'h0006, 0, 32'hFFFF_FFFF, 32'd1), 0, ST_ACCEPTED, 0);
        add_dir(mk(MODE_QUERY, 16'h0000, 0, 0, 0), 1, ST_QUERY, 0);
        // fill the store with non-crossing bids, then overflow it
        for (int i = 0; i < MAX_ORDERS; i++)
            add_dir(mk(MODE_LIMIT, 16'(16'h0100 + i), 1, 32'd1, 32'd2), 0, ST_ACCEPTED, 0);
        add_dir(mk(MODE_LIMIT, 16'h0200, 1, 32'd1, 32'd9), 1, ST_DROPPED, 32'd9);
        // a large market sell against the resting bids, then a small one
        add_dir(mk(MODE_MARKET, 16'h0201, 0, 32'd0, 32'hFFFF_FFFF), 0, ST_ACCEPTED, 0);
        add_dir(mk(MODE_MARKET, 16'h0202, 0, 32'd0, 32'd1), 0, ST_ACCEPTED, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            send_order(dir_rows[n].ord);
            // hand-typed summary must agree with the shadow book
            if (dir_rows[n].has_sum) begin
                last_sum = rows_due[$];
                if (last_sum.status !== dir_rows[n].status ||
                    last_sum.unfilled !== dir_rows[n].unfilled) begin
                    $display("%0t directed row %0d expected %0d/%0d actual %0d/%0d", $time, n,
                             dir_rows[n].status, dir_rows[n].unfilled,
                             last_sum.status, last_sum.unfilled);
                    failures++;
                end
            end
        end

        for (int n = 0; n < 420; n++) begin
            if (n == 380) quiet = 1'b1;
            send_order(rand_order());
        end
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (rows_due.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (failures == 0 && rows_due.size() == 0)
            $display("[limit_order_book_matcher] OK");
        else
            $display("[limit_order_book_matcher] ERROR");
        $finish;
    end

    // timeout guard
    initial begin
        #20000000;
        $display("[limit_order_book_matcher] ERROR");
        $finish;
    end
endmodule

>>> sim.f
+incdir+sv
sv/lobm_pkg.sv
sv/lobm_ctrl.sv
sv/lobm_dp.sv
sv/limit_order_book_matcher.sv
tb/limit_order_book_matcher_test.sv
